FILE: design/hpc_pkg.sv
// ----------------------------------------------------------------------------
// hpc_pkg: shared types and constants for the Huffman path cost unit
// Heap geometry, entry width and the controller state encoding.
// ----------------------------------------------------------------------------
package hpc_pkg;

	localparam int MaxLeaves = 256;
	localparam int AddrW     = $clog2(MaxLeaves);
	localparam int CountW    = AddrW + 1;
	localparam int EntryW    = 24;
	localparam int WeightW   = 16;
	localparam int CostW     = 32;

	typedef logic [EntryW-1:0] entry_t;
	typedef logic [AddrW-1:0]  addr_t;
	typedef logic [CountW-1:0] count_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_POP_RD,
		ST_POP_TOP,
		ST_DN_RD,
		ST_DN_CMP,
		ST_MERGE,
		ST_DONE
	} hpc_state_t;

	// Memory port bundle from controller to heap RAM
	typedef struct packed {
		logic   we;
		addr_t  waddr;
		entry_t wdata;
		addr_t  raddr_a;
		addr_t  raddr_b;
	} hpc_mem_req_t;

endpackage

FILE: design/hpc_ram.sv
// ----------------------------------------------------------------------------
// hpc_ram: heap entry store
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module hpc_ram
	import hpc_pkg::*;
(
	input  logic         clk,
	input  hpc_mem_req_t req,
	output entry_t       rdata_a,
	output entry_t       rdata_b
);

	entry_t mem [MaxLeaves];

	// write and registered reads
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_a <= mem[req.raddr_a];
		rdata_b <= mem[req.raddr_b];
	end

endmodule

FILE: design/hpc_ctrl.sv
// ----------------------------------------------------------------------------
// hpc_ctrl: heap sequencer
// Loads weights with sift-up, then pops two, merges and reinserts until one
// entry is left, accumulating the merged sums.
// ----------------------------------------------------------------------------
module hpc_ctrl
	import hpc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [WeightW-1:0] in_weight,
	input  logic            in_last,
	output logic            res_valid,
	input  logic            res_ready,
	output logic [CostW-1:0] res_cost,
	output logic            res_ovf,
	output hpc_mem_req_t    req,
	input  entry_t          rdata_a,
	input  entry_t          rdata_b
);

	hpc_state_t state_q, state_d;
	count_t     count_q, count_d;
	logic [CostW-1:0] cost_q, cost_d;
	logic       ovf_q, ovf_d;
	logic       last_q, last_d;
	logic       second_q, second_d;   // popping second operand
	addr_t      idx_q, idx_d;          // current node
	entry_t     val_q, val_d;          // value being sifted
	entry_t     first_q, first_d;      // first popped value
	logic [CostW-1:0] res_cost_q, res_cost_d;
	logic       res_ovf_q, res_ovf_d;
	logic       res_valid_q, res_valid_d;

	addr_t  parent, lch, rch;
	count_t lch_w, rch_w;
	logic   l_ok, r_ok;
	entry_t sum;
	logic [CostW:0] acc;

	assign parent = (idx_q - addr_t'(1)) >> 1;
	assign lch_w  = {idx_q, 1'b1};
	assign rch_w  = lch_w + count_t'(1);
	assign lch    = lch_w[AddrW-1:0];
	assign rch    = rch_w[AddrW-1:0];
	assign l_ok   = lch_w < count_q;
	assign r_ok   = rch_w < count_q;
	assign sum    = first_q + rdata_a;
	assign acc    = {1'b0, cost_q} + {{(CostW+1-EntryW){1'b0}}, sum};

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res_cost  = res_cost_q;
	assign res_ovf   = res_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cost_q      <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			cost_q      <= cost_d;
			ovf_q       <= ovf_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		last_q     <= last_d;
		second_q   <= second_d;
		idx_q      <= idx_d;
		val_q      <= val_d;
		first_q    <= first_d;
		res_cost_q <= res_cost_d;
		res_ovf_q  <= res_ovf_d;
	end

	// next state and memory requests
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		cost_d      = cost_q;
		ovf_d       = ovf_q;
		last_d      = last_q;
		second_d    = second_q;
		idx_d       = idx_q;
		val_d       = val_q;
		first_d     = first_q;
		res_cost_d  = res_cost_q;
		res_ovf_d   = res_ovf_q;
		res_valid_d = res_valid_q && !res_ready;
		req         = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					last_d = in_last;
					if (count_q == count_t'(MaxLeaves)) begin
						ovf_d   = 1'b1;
						state_d = in_last ? ST_MERGE : ST_IDLE;
					end else begin
						idx_d   = count_q[AddrW-1:0];
						val_d   = entry_t'(in_weight);
						count_d = count_q + count_t'(1);
						req.we    = 1'b1;
						req.waddr = count_q[AddrW-1:0];
						req.wdata = entry_t'(in_weight);
						state_d   = ST_UP_RD;
					end
				end
			end
			ST_UP_RD: begin
				if (idx_q == '0) begin
					// reached the root: held value settles here
					req.we    = 1'b1;
					req.waddr = '0;
					req.wdata = val_q;
					state_d   = last_q ? ST_MERGE : ST_IDLE;
				end else begin
					req.raddr_a = parent;
					state_d     = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				// parent larger: move parent down, continue upward
				if (rdata_a > val_q) begin
					req.we    = 1'b1;
					req.waddr = idx_q;
					req.wdata = rdata_a;
					idx_d     = parent;
					state_d   = ST_UP_RD;
				end else begin
					req.we    = 1'b1;
					req.waddr = idx_q;
					req.wdata = val_q;
					state_d   = last_q ? ST_MERGE : ST_IDLE;
				end
				if (rdata_a > val_q && parent == '0) begin
					state_d = ST_UP_RD;
				end
			end
			ST_MERGE: begin
				if (count_q > count_t'(1)) begin
					second_d    = 1'b0;
					req.raddr_a = '0;
					req.raddr_b = count_q[AddrW-1:0] - addr_t'(1);
					state_d     = ST_POP_TOP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_POP_RD: begin
				req.raddr_a = '0;
				req.raddr_b = count_q[AddrW-1:0] - addr_t'(1);
				state_d     = ST_POP_TOP;
			end
			ST_POP_TOP: begin
				// take top, move tail to root and sift down
				if (!second_q) first_d = rdata_a;
				val_d   = rdata_b;
				count_d = count_q - count_t'(1);
				idx_d   = '0;
				req.we    = 1'b1;
				req.waddr = '0;
				req.wdata = rdata_b;
				if (second_q) begin
					// second operand in rdata_a: merge, write sum at root
					cost_d    = acc[CostW] ? '1 : acc[CostW-1:0];
					val_d     = sum;
					req.wdata = sum;
					count_d   = count_q;
				end
				state_d = ST_DN_RD;
			end
			ST_DN_RD: begin
				req.raddr_a = lch;
				req.raddr_b = rch;
				state_d     = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				if (l_ok && rdata_a < val_q && !(r_ok && rdata_b < rdata_a)) begin
					req.we    = 1'b1;
					req.waddr = idx_q;
					req.wdata = rdata_a;
					idx_d     = lch;
					state_d   = ST_DN_RD;
				end else if (r_ok && rdata_b < val_q) begin
					req.we    = 1'b1;
					req.waddr = idx_q;
					req.wdata = rdata_b;
					idx_d     = rch;
					state_d   = ST_DN_RD;
				end else begin
					req.we    = 1'b1;
					req.waddr = idx_q;
					req.wdata = val_q;
					if (second_q) begin
						state_d = ST_MERGE;
					end else begin
						second_d = 1'b1;
						state_d  = ST_POP_RD;
					end
				end
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					res_valid_d = 1'b1;
					res_cost_d  = cost_q;
					res_ovf_d   = ovf_q;
					count_d     = '0;
					cost_d      = '0;
					ovf_d       = 1'b0;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// checks on heap capacity, result hold under stall, and result post with heap clear
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= count_t'(MaxLeaves))
		else $error("heap count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_valid_q && !res_ready) |=> state_q == ST_DONE)
		else $error("result dropped while output stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && state_d == ST_IDLE) |=> (res_valid_q && count_q == '0))
		else $error("result not posted or heap not cleared");

endmodule

FILE: design/huffman_path_cost_unit.sv
// ----------------------------------------------------------------------------
// huffman_path_cost_unit: Huffman weighted path length
// Weights stream into a binary min-heap held in RAM; on the last beat the
// unit merges the two smallest repeatedly and reports the sum of merges.
// ----------------------------------------------------------------------------
// Each weight beat is written at the heap tail and sifted up, with one read and
// one compare state per level (up to 8 levels). After the last beat each merge
// pops twice: the first pop moves the tail to the root, the second writes the
// sum at the root, and each is followed by a sift-down. All accesses share the
// single heap RAM with its registered read ports. Weights past 256 are
// dropped and flag overflow.
module huffman_path_cost_unit
	import hpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // weight[15:0]
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // path_cost[31:0], overflow[32], zero fill
);

	hpc_mem_req_t req;
	entry_t rdata_a, rdata_b;
	logic [CostW-1:0] cost;
	logic ovf;

	hpc_ram u_ram (
		.clk(clk), .req(req), .rdata_a(rdata_a), .rdata_b(rdata_b)
	);

	hpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_weight(s_tdata), .in_last(s_tlast),
		.res_valid(m_tvalid), .res_ready(m_tready),
		.res_cost(cost), .res_ovf(ovf),
		.req(req), .rdata_a(rdata_a), .rdata_b(rdata_b)
	);

	assign m_tdata = {7'd0, ovf, cost};

endmodule

FILE: sim/huffman_path_cost_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_path_cost_unit_tb: self-checking bench for the Huffman path cost unit
// Streams weight sets (directed edge cases, then random sets of mostly small
// size with a few full and overflowing ones) and compares every cost beat
// against a sorted-queue merge predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
module huffman_path_cost_unit_tb;
	import hpc_pkg::*;

	typedef struct {
		logic [CostW-1:0] path_cost;
		logic             overflow;
	} cost_beat_t;

	// Scoreboard: tracks the current weight set and queues expected costs
	class cost_board;
		logic [CostW-1:0] set_weights[$];
		logic             set_dropped = 1'b0;
		cost_beat_t       pending[$];
		int               mismatches;
		int               checked;

		function void note_weight(logic [WeightW-1:0] w, logic last);
			logic [CostW-1:0] heap[$];
			logic [CostW-1:0] a, b, s, total;
			if (set_weights.size() >= MaxLeaves) set_dropped = 1'b1;
			else set_weights.push_back({{(CostW-WeightW){1'b0}}, w});
			if (!last) return;
			// Merge two smallest repeatedly; sorted queue stands in for the heap
			heap = set_weights;
			heap.sort();
			total = '0;
			while (heap.size() > 1) begin
				a = heap.pop_front();
				b = heap.pop_front();
				s = a + b;
				total = (total > 32'hFFFF_FFFF - s) ? 32'hFFFF_FFFF : total + s;
				insert_sorted(heap, s);
			end
			pending.push_back('{total, set_dropped});
			set_weights.delete();
			set_dropped = 1'b0;
		endfunction

		function void insert_sorted(ref logic [CostW-1:0] q[$], input logic [CostW-1:0] v);
			int i;
			i = 0;
			while (i < q.size() && q[i] <= v) i++;
			q.insert(i, v);
		endfunction

		function void check_cost(logic [39:0] data);
			cost_beat_t exp_beat;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("ERROR: unexpected cost beat %h", data);
				return;
			end
			exp_beat = pending.pop_front();
			if (data[31:0] !== exp_beat.path_cost || data[32] !== exp_beat.overflow) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: cost exp %0d ovf %0b, got %0d ovf %0b",
						exp_beat.path_cost, exp_beat.overflow, data[31:0], data[32]);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	cost_board   board = new();
	int          cycles = 0;
	int          beats_sent = 0;
	int          sets_sent = 0;
	bit          calm = 1'b0;
	bit          stim_done = 1'b0;

	localparam int CycleLimit = 3_000_000;

	always #5 clk = ~clk;

	huffman_path_cost_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Cycle limit watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("huffman_path_cost_unit verification failed");
			$finish;
		end
	end

	// Result side: check accepted beats, random stall bursts
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) board.check_cost(m_tdata);
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(1, 12) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Drive one weight beat; hold it until accepted
	task automatic send_weight(logic [15:0] w, logic last);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_weight(w, last);
		beats_sent++;
		if (last) sets_sent++;
	endtask

	task automatic send_set(int n, int mode);
		logic [15:0] w;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: w = 16'($urandom_range(0, 65535));
				1: w = 16'hFFFF;
				2: w = '0;
				3: w = 16'($urandom_range(0, 15));
				default: w = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
			endcase
			send_weight(w, i == n - 1);
		end
	endtask

	initial begin
		int n, r, waited;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single weights at extremes, pairs, a mixed set of four, all-zero and all-max
		send_weight(16'h0000, 1'b1);
		send_weight(16'hFFFF, 1'b1);
		send_weight(16'hFFFF, 1'b0);
		send_weight(16'hFFFF, 1'b1);
		send_weight(16'h0001, 1'b0);
		send_weight(16'h0000, 1'b1);
		send_weight(16'h5555, 1'b0);
		send_weight(16'hAAAA, 1'b0);
		send_weight(16'h00FF, 1'b0);
		send_weight(16'hFF00, 1'b1);
		send_set(4, 2);
		send_set(6, 1);

		// Full store, then overflow including a dropped last beat
		send_set(MaxLeaves, 1);
		send_set(MaxLeaves + 3, 0);

		// Random sets, mostly small
		while (beats_sent < 1650) begin
			r = $urandom_range(0, 39);
			if (r == 0) n = MaxLeaves + int'($urandom_range(0, 4));
			else if (r < 4) n = $urandom_range(20, 60);
			else n = $urandom_range(1, 12);
			if (beats_sent > 1400) calm = 1'b1;
			send_set(n, $urandom_range(0, 4));
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
		stim_done = 1'b1;

		waited = 0;
		while (board.pending.size() != 0 && waited < 200_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);

		$display("Sent %0d weight beats in %0d sets, checked %0d cost beats.",
			beats_sent, sets_sent, board.checked);
		if (board.pending.size() != 0 || board.mismatches != 0) begin
			$display("Mismatches %0d, outstanding %0d", board.mismatches,
				board.pending.size());
			$display("huffman_path_cost_unit verification failed");
		end else begin
			$display("huffman_path_cost_unit verification clean");
		end
		$finish;
	end

endmodule
